@@ src/gtmi_pkg.sv @@
// Shared types, constants and the blend function of the grid table interpolator.
`default_nettype none
package gtmi_pkg;

   localparam int TABLE_DEPTH_DEF = 4096;
   localparam int MAX_AXES        = 3;
   localparam int AXES            = 3;
   localparam int CORNERS         = 8;
   localparam int PTS_W           = 13;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 39;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_1    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_2    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_3    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_1     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_2     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_3     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_POINTS = 3'd6;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FEW   = 2'd2;
   localparam logic [1:0] STATUS_SAT   = 2'd3;

   localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

   typedef struct packed {
      logic               command;
      logic [11:0]        entry_address;
      logic signed [31:0] entry_value;
      logic signed [31:0] coord_1;
      logic signed [31:0] coord_2;
      logic signed [31:0] coord_3;
      logic [1:0]         axis_count;
      logic               clamp_outside;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic               wr;
      logic [1:0]         err;
      logic [11:0]        waddr;
      logic [31:0]        wdata;
      logic [AXES-1:0][15:0] frac;
   } tag_type;

   typedef struct packed {
      logic               sat;
      logic signed [31:0] val;
   } blend_type;

   function automatic blend_type blend(input logic signed [31:0] a,
                                       input logic signed [31:0] b,
                                       input logic [15:0] f);
      logic signed [17:0] wa;
      logic signed [17:0] wb;
      logic signed [49:0] pa;
      logic signed [49:0] pb;
      logic signed [49:0] s;
      logic signed [33:0] q;
      blend_type          r;
      wa = 18'sd65536 - $signed({2'b00, f});
      wb = $signed({2'b00, f});
      pa = a * wa;
      pb = b * wb;
      s  = pa + pb + 50'sd32768;
      q  = s[49:16];
      r.sat = 1'b0;
      r.val = q[31:0];
      if (q[33] == 1'b0 && q[32:31] != 2'b00) begin
         r.sat = 1'b1;
         r.val = 32'sh7FFF_FFFF;
      end else if (q[33] == 1'b1 && q[32:31] != 2'b11) begin
         r.sat = 1'b1;
         r.val = 32'sh8000_0000;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ src/grid_table_multilinear_interp_core.sv @@
// Top level of the grid table multilinear interpolator.
`default_nettype none
// Multilinear lookup on a uniform 1-D, 2-D or 3-D grid. Write items load the
// sample table, evaluate items return the blended value; each item gives one
// result. Ten register stages, one item accepted per cycle while the output is not
// stalled; the result is offered from the last stage and waits there while rsp_ready is low.
// The eight corner reads per cycle come from four copies of the table with two
// read ports each, all written together, so the table memory port count sets the
// rate. The user must keep TABLE_DEPTH a power of two (the block does not enforce it);
// corner and write addresses wrap at it. Table entries read before being written are undefined.
module grid_table_multilinear_interp_core
   import gtmi_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire req_type               req_payload,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      rsp_type               rsp_payload,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int NCOPY = CORNERS / 2;

   logic signed [31:0] origin_ff [AXES];
   logic [31:0]        scale_ff [AXES];
   logic [CSR_DATA_W-1:0] points_ff;

   logic       en;
   logic [10:1] v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            origin_ff[a] <= '0;
            scale_ff[a]  <= SCALE_RESET;
         end
         points_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_1:    origin_ff[0] <= csr_wdata[31:0];
            CSR_ORIGIN_2:    origin_ff[1] <= csr_wdata[31:0];
            CSR_ORIGIN_3:    origin_ff[2] <= csr_wdata[31:0];
            CSR_SCALE_1:     scale_ff[0]  <= csr_wdata[31:0];
            CSR_SCALE_2:     scale_ff[1]  <= csr_wdata[31:0];
            CSR_SCALE_3:     scale_ff[2]  <= csr_wdata[31:0];
            CSR_GRID_POINTS: points_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign en        = !v_ff[10] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = v_ff[10];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[9:1], req_valid};
      end
   end

   // stage 1: input register
   req_type req_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         req_ff <= req_payload;
      end
   end

   // stage 2: offsets from origin, point count check
   logic [1:0]             kk;
   logic [AXES-1:0]        used_in;
   logic [PTS_W-1:0]       np_in [AXES];
   logic signed [31:0]     crd [AXES];
   logic                   few;
   logic signed [32:0]     d_in [AXES];
   tag_type                tag2_in;

   logic signed [32:0]     d2_ff [AXES];
   logic [AXES-1:0]        used2_ff;
   logic [PTS_W-1:0]       np2_ff [AXES];
   logic                   clamp2_ff;
   tag_type                tag2_ff;

   always_comb begin
      crd[0] = req_ff.coord_1;
      crd[1] = req_ff.coord_2;
      crd[2] = req_ff.coord_3;
      kk = req_ff.axis_count;
      if (kk == 2'd0) begin
         kk = 2'd1;
      end
      if (kk > 2'(MAX_AXES)) begin
         kk = 2'(MAX_AXES);
      end
      few = 1'b0;
      for (int a = 0; a < AXES; a++) begin
         used_in[a] = 2'(a) < kk;
         np_in[a]   = used_in[a] ? points_ff[PTS_W*a +: PTS_W] : PTS_W'(1);
         if (used_in[a] && np_in[a] < PTS_W'(2)) begin
            few = 1'b1;
         end
         d_in[a] = {crd[a][31], crd[a]} - {origin_ff[a][31], origin_ff[a]};
      end
      tag2_in.wr    = req_ff.command == CMD_WRITE;
      tag2_in.err   = few ? STATUS_FEW : STATUS_OK;
      tag2_in.waddr = req_ff.entry_address;
      tag2_in.wdata = req_ff.entry_value;
      tag2_in.frac  = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff     <= d_in;
         used2_ff  <= used_in;
         np2_ff    <= np_in;
         clamp2_ff <= req_ff.clamp_outside;
         tag2_ff   <= tag2_in;
      end
   end

   // stage 3: grid position
   logic [63:0]       p3_ff [AXES];
   logic [AXES-1:0]   neg3_ff;
   logic [AXES-1:0]   used3_ff;
   logic [PTS_W-1:0]  np3_ff [AXES];
   logic              clamp3_ff;
   tag_type           tag3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < AXES; a++) begin
            p3_ff[a]   <= d2_ff[a][31:0] * scale_ff[a];
            neg3_ff[a] <= d2_ff[a][32];
         end
         used3_ff  <= used2_ff;
         np3_ff    <= np2_ff;
         clamp3_ff <= clamp2_ff;
         tag3_ff   <= tag2_ff;
      end
   end

   // stage 4: cell index, fraction, range check
   logic [PTS_W-1:0] idx_in [AXES];
   logic [AXES-1:0]  inc_in;
   logic [AXES-1:0]  out_in;
   logic [PTS_W-1:0] last;
   logic [31:0]      hi;
   tag_type          tag4_in;

   logic [PTS_W-1:0] idx4_ff [AXES];
   logic [AXES-1:0]  inc4_ff;
   logic [PTS_W-1:0] np4_ff [AXES];
   tag_type          tag4_ff;

   always_comb begin
      tag4_in = tag3_ff;
      last    = '0;
      hi      = '0;
      for (int a = 0; a < AXES; a++) begin
         last      = np3_ff[a] - PTS_W'(1);
         hi        = p3_ff[a][63:32];
         idx_in[a] = '0;
         inc_in[a] = 1'b0;
         out_in[a] = 1'b0;
         tag4_in.frac[a] = '0;
         if (!used3_ff[a]) begin
            idx_in[a] = '0;
         end else if (neg3_ff[a]) begin
            out_in[a] = 1'b1;
         end else if (hi > 32'(last) || (hi == 32'(last) && p3_ff[a][31:0] != '0)) begin
            idx_in[a] = last;
            out_in[a] = 1'b1;
         end else if (hi == 32'(last)) begin
            idx_in[a] = last;
         end else begin
            idx_in[a] = hi[PTS_W-1:0];
            inc_in[a] = 1'b1;
            tag4_in.frac[a] = p3_ff[a][31:16];
         end
      end
      if (tag3_ff.err == STATUS_OK && out_in != '0 && !clamp3_ff) begin
         tag4_in.err = STATUS_RANGE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         idx4_ff <= idx_in;
         inc4_ff <= inc_in;
         np4_ff  <= np3_ff;
         tag4_ff <= tag4_in;
      end
   end

   // stage 5: row offsets over axes one and two
   logic [AW-1:0]    row_in [4];
   logic [PTS_W-1:0] i1;
   logic [PTS_W-1:0] i2;
   logic [2*PTS_W:0] rt;

   logic [AW-1:0]    row5_ff [4];
   logic [PTS_W-1:0] idx5_ff;
   logic             inc5_ff;
   logic [PTS_W-1:0] np5_ff;
   tag_type          tag5_ff;

   always_comb begin
      i1 = '0;
      i2 = '0;
      rt = '0;
      for (int j = 0; j < 4; j++) begin
         i1 = idx4_ff[0] + (((j & 1) != 0) ? PTS_W'(inc4_ff[0]) : PTS_W'(0));
         i2 = idx4_ff[1] + (((j & 2) != 0) ? PTS_W'(inc4_ff[1]) : PTS_W'(0));
         rt = i1 * np4_ff[1] + i2;
         row_in[j] = AW'(rt);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         row5_ff <= row_in;
         idx5_ff <= idx4_ff[2];
         inc5_ff <= inc4_ff[2];
         np5_ff  <= np4_ff[2];
         tag5_ff <= tag4_ff;
      end
   end

   // stage 6: corner addresses
   logic [AW-1:0]     addr_in [CORNERS];
   logic [PTS_W-1:0]  i3;
   logic [AW+PTS_W:0] at;

   logic [AW-1:0]     addr6_ff [CORNERS];
   tag_type           tag6_ff;

   always_comb begin
      i3 = '0;
      at = '0;
      for (int j = 0; j < CORNERS; j++) begin
         i3 = idx5_ff + (((j & 4) != 0) ? PTS_W'(inc5_ff) : PTS_W'(0));
         at = row5_ff[j & 3] * np5_ff + i3;
         addr_in[j] = AW'(at);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         addr6_ff <= addr_in;
         tag6_ff  <= tag5_ff;
      end
   end

   // stage 7: table copies, written in item order with the reads
   logic               we;
   logic signed [31:0] c7_ff [CORNERS];
   tag_type            tag7_ff;

   assign we = en && v_ff[6] && tag6_ff.wr;

   for (genvar m = 0; m < NCOPY; m++) begin : g_copy
      logic [31:0] mem [TABLE_DEPTH];
      always_ff @(posedge clock) begin
         if (we) begin
            mem[AW'(tag6_ff.waddr)] <= tag6_ff.wdata;
         end
         if (en) begin
            c7_ff[2*m]   <= mem[addr6_ff[2*m]];
            c7_ff[2*m+1] <= mem[addr6_ff[2*m+1]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag7_ff <= tag6_ff;
      end
   end

   // stage 8: reduce axis three
   blend_type          b8 [4];
   logic signed [31:0] c8_ff [4];
   logic               sat8_ff;
   tag_type            tag8_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         b8[j] = blend(c7_ff[j], c7_ff[j+4], tag7_ff.frac[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 4; j++) begin
            c8_ff[j] <= b8[j].val;
         end
         sat8_ff <= b8[0].sat | b8[1].sat | b8[2].sat | b8[3].sat;
         tag8_ff <= tag7_ff;
      end
   end

   // stage 9: reduce axis two
   blend_type          b9 [2];
   logic signed [31:0] c9_ff [2];
   logic               sat9_ff;
   tag_type            tag9_ff;

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         b9[j] = blend(c8_ff[j], c8_ff[j+2], tag8_ff.frac[1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 2; j++) begin
            c9_ff[j] <= b9[j].val;
         end
         sat9_ff <= sat8_ff | b9[0].sat | b9[1].sat;
         tag9_ff <= tag8_ff;
      end
   end

   // stage 10: reduce axis one, form the result
   blend_type b10;
   rsp_type   rsp_in;
   rsp_type   rsp_ff;

   always_comb begin
      b10 = blend(c9_ff[0], c9_ff[1], tag9_ff.frac[0]);
      rsp_in.value  = b10.val;
      rsp_in.status = (sat9_ff || b10.sat) ? STATUS_SAT : STATUS_OK;
      if (tag9_ff.wr) begin
         rsp_in.value  = '0;
         rsp_in.status = STATUS_OK;
      end else if (tag9_ff.err != STATUS_OK) begin
         rsp_in.value  = '0;
         rsp_in.status = tag9_ff.err;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire
